@@ hw/rtl/cfcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_pkg
// Shared constants and types for the 1/9/22 float classifier and converter.
// ----------------------------------------------------------------------------
package cfcc_pkg;

    localparam int unsigned FracW     = 22;
    localparam int unsigned ExpW      = 9;
    localparam int unsigned NormBias  = 255;
    localparam int unsigned DenBias   = 254;
    localparam int unsigned DblBias   = 1023;
    localparam int unsigned DblFracW  = 52;
    localparam int unsigned LzcW      = 5;

    localparam logic [2:0] CLASS_NORMAL   = 3'd0;
    localparam logic [2:0] CLASS_DENORMAL = 3'd1;
    localparam logic [2:0] CLASS_ZERO     = 3'd2;
    localparam logic [2:0] CLASS_INF      = 3'd3;
    localparam logic [2:0] CLASS_NAN      = 3'd4;

    typedef struct packed {
        logic [2:0]       cls;
        logic             neg;
        logic [ExpW-1:0]  ex;
        logic [FracW-1:0] fr;
    } cfcc_item_t;

endpackage : cfcc_pkg
`default_nettype wire

@@ hw/rtl/cfcc_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_norm
// Leading-one position and normalising shift of a denormal fraction, in two
// register stages that stall together.
// ----------------------------------------------------------------------------
module cfcc_norm
    import cfcc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire cfcc_item_t       in_item,
    output logic                  out_valid,
    output cfcc_item_t            out_item,
    output logic [LzcW-1:0]       out_pos,
    output logic [FracW-1:0]      out_frac
);

    logic             v1_reg;
    cfcc_item_t       it1_reg;
    logic [LzcW-1:0]  pos1_reg;
    logic [LzcW-1:0]  pos_next;
    logic             v2_reg;
    cfcc_item_t       it2_reg;
    logic [LzcW-1:0]  pos2_reg;
    logic [FracW-1:0] frac2_reg;

    // Highest set bit, falling to zero when none is found, as the loop does.
    always_comb
    begin
        pos_next = '0;
        for (int i = 1; i < FracW; i++)
        begin
            if (in_item.fr[i])
            begin
                pos_next = LzcW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg   <= in_item;
            pos1_reg  <= pos_next;
            it2_reg   <= it1_reg;
            pos2_reg  <= pos1_reg;
            // Shift the leading one out past the top; the rest stays aligned.
            frac2_reg <= it1_reg.fr << (FracW - int'(pos1_reg));
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = it2_reg;
    assign out_pos   = pos2_reg;
    assign out_frac  = frac2_reg;

endmodule : cfcc_norm
`default_nettype wire

@@ hw/rtl/custom_float_classify_convert_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// custom_float_classify_convert_core
// Classifies a 1/9/22 float word; normals and denormals convert exactly to a double.
// ----------------------------------------------------------------------------
// One word enters per clock while the pipeline advances: stage one classifies,
// stages two and three find and shift out the leading one of a denormal, stage
// four packs the double into the output register. All stages advance together
// when the output register is empty or being taken, and all hold while a
// result waits on out_ready.
module custom_float_classify_convert_core
    import cfcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] word_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       value_class,
    output logic             is_negative,
    output logic [63:0]      double_bits
);

    logic             adv;
    logic             v0_reg;
    cfcc_item_t       it0_reg;
    cfcc_item_t       c_next;
    logic             nv;
    cfcc_item_t       nit;
    logic [LzcW-1:0]  npos;
    logic [FracW-1:0] nfrac;
    logic             ov_reg;
    logic [2:0]       cls_reg;
    logic             neg_reg;
    logic [63:0]      bits_reg;
    logic [63:0]      bits_next;
    logic [10:0]      bexp;

    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        c_next.neg = word_in[31];
        c_next.ex  = word_in[30:22];
        c_next.fr  = word_in[21:0];
        if (c_next.ex == '0 && c_next.fr == '0)
            c_next.cls = CLASS_ZERO;
        else if (c_next.ex == '1)
            c_next.cls = (c_next.fr == '0) ? CLASS_INF : CLASS_NAN;
        else if (c_next.ex != '0)
            c_next.cls = CLASS_NORMAL;
        else
            c_next.cls = CLASS_DENORMAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            it0_reg <= c_next;
    end

    cfcc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v0_reg),
        .in_item   (it0_reg),
        .out_valid (nv),
        .out_item  (nit),
        .out_pos   (npos),
        .out_frac  (nfrac)
    );

    always_comb
    begin
        bits_next = '0;
        bexp      = '0;
        case (nit.cls)
            CLASS_NORMAL:
            begin
                bexp      = 11'(DblBias - NormBias) + 11'(nit.ex);
                bits_next = {nit.neg, bexp, nit.fr, 30'd0};
            end
            CLASS_DENORMAL:
            begin
                bexp      = 11'(DblBias - DenBias - FracW) + 11'(npos);
                bits_next = {nit.neg, bexp, nfrac, 30'd0};
            end
            default:
            begin
                bits_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= nv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg  <= nit.cls;
            neg_reg  <= nit.neg;
            bits_reg <= bits_next;
        end
    end

    assign out_valid   = ov_reg;
    assign value_class = cls_reg;
    assign is_negative = neg_reg;
    assign double_bits = bits_reg;

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("ready low with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(double_bits))
        else $error("result lost under stall");
    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (value_class == CLASS_ZERO || value_class == CLASS_INF
        || value_class == CLASS_NAN) |-> double_bits == 64'd0)
        else $error("special class with non-zero value");
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (value_class == CLASS_NORMAL || value_class == CLASS_DENORMAL)
        |-> double_bits[63] == is_negative) else $error("sign mismatch");

endmodule : custom_float_classify_convert_core
`default_nettype wire
